// File: src/assert_macros.svh
// Assertion macros used by the undo stack engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, checked on every rising edge out of reset.
`define USM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("undo stack assertion failed");

// Implication in the next cycle, checked on every rising edge out of reset.
`define USM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("undo stack assertion failed");

`endif

// File: src/usm_pkg.sv
// Types and codes shared by the undo stack modules.
`timescale 1ns / 1ps
package usm_pkg;

  // Default number of stack entries.
  localparam int DEPTH_DEF = 64;

  // Command codes of the input word.
  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_MARK   = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // Status codes of the result word.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_IGNORED  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_NO_MARK  = 2'd3;

  // Input word.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  op_type;
    logic [31:0] op_object;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic        is_entry;
    logic [7:0]  undo_type;
    logic [31:0] undo_object;
    logic [1:0]  status;
    logic [6:0]  milestone_level;
    logic        last;
  } out_word_t;

  // Decoded command as it travels from the front end to the back end.
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  op_type;
    logic [31:0] op_object;
  } job_word_t;

  // One stack entry.
  typedef struct packed {
    logic        is_mark;
    logic [7:0]  kind;
    logic [31:0] handle;
  } entry_t;

endpackage

// File: src/usm_front.sv
// Front end: takes input words, decodes the command and holds it in a register.
`timescale 1ns / 1ps
module usm_front import usm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      fr_valid,
  input  logic      fr_ready,
  output job_word_t fr_job
);

  logic      valid_r, valid_nxt;
  job_word_t job_r, job_nxt;
  logic      accept;

  // The register may take a new word whenever its contents leave in the same cycle.
  assign in_ready = !valid_r || fr_ready;
  assign accept   = in_valid && in_ready;
  assign fr_valid = valid_r;
  assign fr_job   = job_r;

  // Decode: only a record carries a payload onwards; other commands clear it.
  always_comb begin
    valid_nxt = valid_r && !fr_ready;
    job_nxt   = job_r;
    if (accept) begin
      valid_nxt  = 1'b1;
      job_nxt.op = in_data.cmd;
      unique case (in_data.cmd)
        CMD_RECORD: begin
          job_nxt.op_type   = in_data.op_type;
          job_nxt.op_object = in_data.op_object;
        end
        default: begin
          job_nxt.op_type   = '0;
          job_nxt.op_object = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    job_r <= job_nxt;
  end

endmodule

// File: src/usm_cmd_fifo.sv
// Two-word queue that decouples the command front end from the stack engine.
`timescale 1ns / 1ps
module usm_cmd_fifo import usm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s_valid,
  output logic      s_ready,
  input  job_word_t s_job,
  output logic      m_valid,
  input  logic      m_ready,
  output job_word_t m_job
);

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  job_word_t        slot_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             push, pop;

  assign s_ready = cnt_r != QCW'(QDEPTH);
  assign m_valid = cnt_r != '0;
  assign m_job   = slot_r[rp_r];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  // Pointer and count update.
  always_comb begin
    wp_nxt  = push ? QAW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = pop ? QAW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= s_job;
    end
  end

endmodule

// File: src/usm_back.sv
// Stack engine: holds the entry store and counters, executes commands, drives results.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module usm_back import usm_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  job_word_t q_job,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic BK_IDLE = 1'b0;
  localparam logic BK_POP  = 1'b1;

  // Entry store and its registered read port.
  entry_t         mem [DEPTH];
  entry_t         rd_q;
  logic           wr_en, rd_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  entry_t         wr_data;

  logic           state_r, state_nxt;
  logic [CW-1:0]  fill_r, fill_nxt, open_r, open_nxt, ptr_r, ptr_nxt;
  logic [CW-1:0]  fill_dec, ptr_dec, ptr_dec2;
  logic           out_valid_r, out_valid_nxt;
  out_word_t      out_r, out_nxt;
  logic           slot_free, full, take, pop_done;

  function automatic out_word_t done_word(input logic [1:0] st, input logic [CW-1:0] lvl);
    out_word_t w;
    w                 = '0;
    w.status          = st;
    w.milestone_level = 7'(lvl);
    w.last            = 1'b1;
    return w;
  endfunction

  assign slot_free = !out_valid_r || out_ready;
  assign full      = fill_r == CW'(DEPTH);
  assign fill_dec  = fill_r - CW'(1);
  assign ptr_dec   = ptr_r - CW'(1);
  assign ptr_dec2  = ptr_r - CW'(2);
  assign q_ready   = (state_r == BK_IDLE) && slot_free;
  assign take      = q_valid && q_ready;
  assign wr_addr   = fill_r[AW-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Command execution and the pop walk. During a pop rd_q always holds entry ptr_r - 1.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    open_nxt      = open_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = fill_dec[AW-1:0];
    pop_done      = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (take) begin
          unique case (q_job.op)
            CMD_RECORD: begin
              if (open_r == '0) begin
                out_nxt = done_word(ST_IGNORED, open_r);
              end else if (full) begin
                out_nxt = done_word(ST_OVERFLOW, open_r);
              end else begin
                wr_en          = 1'b1;
                wr_data.kind   = q_job.op_type;
                wr_data.handle = q_job.op_object;
                fill_nxt       = fill_r + CW'(1);
                out_nxt        = done_word(ST_OK, open_r);
              end
              out_valid_nxt = 1'b1;
            end
            CMD_MARK: begin
              if (full) begin
                out_nxt = done_word(ST_OVERFLOW, open_r);
              end else begin
                wr_en           = 1'b1;
                wr_data.is_mark = 1'b1;
                fill_nxt        = fill_r + CW'(1);
                open_nxt        = open_r + CW'(1);
                out_nxt         = done_word(ST_OK, open_nxt);
              end
              out_valid_nxt = 1'b1;
            end
            CMD_POP: begin
              if (open_r == '0) begin
                out_nxt       = done_word(ST_NO_MARK, open_r);
                out_valid_nxt = 1'b1;
              end else begin
                // The mark counts as gone for every result of this pop.
                open_nxt  = open_r - CW'(1);
                ptr_nxt   = fill_r;
                rd_en     = 1'b1;
                rd_addr   = fill_dec[AW-1:0];
                state_nxt = BK_POP;
              end
            end
            default: begin
              out_nxt       = done_word(ST_OK, open_r);
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      BK_POP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (rd_q.is_mark) begin
            out_nxt   = done_word(ST_OK, open_r);
            fill_nxt  = ptr_dec;
            state_nxt = BK_IDLE;
            pop_done  = 1'b1;
          end else begin
            out_nxt                 = '0;
            out_nxt.is_entry        = 1'b1;
            out_nxt.undo_type       = rd_q.kind;
            out_nxt.undo_object     = rd_q.handle;
            out_nxt.status          = ST_OK;
            out_nxt.milestone_level = 7'(open_r);
            ptr_nxt                 = ptr_dec;
            rd_en                   = 1'b1;
            rd_addr                 = ptr_dec2[AW-1:0];
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Entry store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      fill_r      <= '0;
      open_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      open_r      <= open_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  // Every open milestone occupies an entry, and the store never overfills.
  `USM_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= CW'(DEPTH))
  `USM_ASSERT_IMP(a_open_bound, state_r == BK_IDLE, open_r <= fill_r)
  // Reaching the mark always closes the pop with a final word.
  `USM_ASSERT_NXT(a_pop_close, pop_done, out_valid_r && out_r.last && !out_r.is_entry)
  // An undone entry is never the final word and always carries status ok.
  `USM_ASSERT_IMP(a_entry_word, out_valid_r && out_r.is_entry,
                  !out_r.last && out_r.status == ST_OK)

endmodule

// File: src/undo_stack_with_milestones_core.sv
// Top level of the undo stack with milestones: front end, command queue and stack engine.
//
//   Channel   Direction  Handshake              Word
//   in_       input      in_valid / in_ready    in_word_t  (cmd, op_type, op_object)
//   out_      output     out_valid / out_ready  out_word_t (entry or final word)
//
// A pop first starts the store read, then gives one word per undone entry and then
// the final word; the single read port of the store sets this order.
// A word passes through the front register, the queue and the output register.
// Output stalls hold the engine, and the queue keeps accepting input until it fills.
// Reset is synchronous, active low.
`timescale 1ns / 1ps
module undo_stack_with_milestones_core import usm_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      fr_valid, fr_ready;
  job_word_t fr_job;
  logic      q_valid, q_ready;
  job_word_t q_job;

  // Decode stage.
  usm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_job   (fr_job)
  );

  // Queue between decode and execution.
  usm_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (fr_valid),
    .s_ready (fr_ready),
    .s_job   (fr_job),
    .m_valid (q_valid),
    .m_ready (q_ready),
    .m_job   (q_job)
  );

  // Stack engine.
  usm_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_job     (q_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: dv/undo_checker.sv
// Checker for the undo stack: predicts every result word from the accepted commands and compares.
`timescale 1ns / 1ps
module undo_trail_checker import usm_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending_words
);

  // Private copy of the stack contents and its two counters.
  logic [7:0]  trail_kind   [DEPTH];
  logic [31:0] trail_handle [DEPTH];
  bit          trail_mark   [DEPTH];
  int          trail_fill;
  int          open_marks;

  // Result words still owed by the block, oldest first.
  out_word_t   owed_words [$];
  int          errors;

  initial begin
    trail_fill    = 0;
    open_marks    = 0;
    errors        = 0;
    fail_count    = 0;
    pending_words = 0;
  end

  // Every word of a command carries the milestone level after that command.
  function automatic out_word_t undo_word(bit is_entry, logic [7:0] kind, logic [31:0] handle,
                                          logic [1:0] st, bit last);
    out_word_t w;
    w.is_entry        = is_entry;
    w.undo_type       = kind;
    w.undo_object     = handle;
    w.status          = st;
    w.milestone_level = 7'(open_marks);
    w.last            = last;
    return w;
  endfunction

  // Applies one command to the private stack and queues the words it must produce.
  function automatic void apply_command(in_word_t w);
    logic [1:0] st;
    int         mark_pos;
    int         i;
    st = ST_OK;
    case (w.cmd)
      CMD_RECORD: begin
        if (open_marks == 0) begin
          st = ST_IGNORED;
        end else if (trail_fill >= DEPTH) begin
          st = ST_OVERFLOW;
        end else begin
          trail_kind[trail_fill]   = w.op_type;
          trail_handle[trail_fill] = w.op_object;
          trail_mark[trail_fill]   = 1'b0;
          trail_fill++;
        end
      end
      CMD_MARK: begin
        if (trail_fill >= DEPTH) begin
          st = ST_OVERFLOW;
        end else begin
          trail_kind[trail_fill]   = '0;
          trail_handle[trail_fill] = '0;
          trail_mark[trail_fill]   = 1'b1;
          trail_fill++;
          open_marks++;
        end
      end
      CMD_POP: begin
        if (open_marks == 0) begin
          st = ST_NO_MARK;
        end else begin
          // The mark goes first, so the entry words already show the lower level.
          open_marks--;
          mark_pos = trail_fill - 1;
          while (mark_pos > 0 && !trail_mark[mark_pos]) mark_pos--;
          for (i = trail_fill - 1; i > mark_pos; i--) begin
            owed_words.push_back(undo_word(1'b1, trail_kind[i], trail_handle[i], ST_OK, 1'b0));
          end
          trail_fill = mark_pos;
        end
      end
      default: begin
      end
    endcase
    owed_words.push_back(undo_word(1'b0, '0, '0, st, 1'b1));
  endfunction

  // Sample both channels at the edge and compare each accepted result word.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) apply_command(in_data);
      if (out_valid && out_ready) begin
        if (owed_words.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result word with none owed: entry=%0d type=%h object=%h status=%0d level=%0d last=%0d",
                     $time, out_data.is_entry, out_data.undo_type, out_data.undo_object,
                     out_data.status, out_data.milestone_level, out_data.last);
          end
        end else begin
          want = owed_words.pop_front();
          if (out_data.is_entry !== want.is_entry || out_data.undo_type !== want.undo_type ||
              out_data.undo_object !== want.undo_object || out_data.status !== want.status ||
              out_data.milestone_level !== want.milestone_level ||
              out_data.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch: wanted entry=%0d type=%h object=%h status=%0d level=%0d last=%0d",
                       $time, want.is_entry, want.undo_type, want.undo_object, want.status,
                       want.milestone_level, want.last);
              $display("%0t:           got    entry=%0d type=%h object=%h status=%0d level=%0d last=%0d",
                       $time, out_data.is_entry, out_data.undo_type, out_data.undo_object,
                       out_data.status, out_data.milestone_level, out_data.last);
            end
          end
        end
      end
      fail_count    <= errors;
      pending_words <= owed_words.size();
    end
  end

endmodule

// File: dv/tb_top.sv
// Testbench top for the undo stack: clock, reset, command stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module tb_top;
  import usm_pkg::*;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE} phase_t;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 55;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  int        fail_count;
  int        pending_words;
  phase_t    phase = PH_FREE;

  // Rough view of the stack, used only to steer the stimulus.
  int        seg_sizes [$];
  int        shadow_fill = 0;

  undo_stack_with_milestones_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  undo_trail_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Percentages of idle cycles on each side for the current phase.
  function automatic int send_idle_pct(phase_t ph);
    case (ph)
      PH_SEND_IDLE: return 82;
      PH_BOTH:      return 26;
      default:      return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(phase_t ph);
    case (ph)
      PH_RECV_STALL: return 82;
      PH_BOTH:       return 26;
      default:       return 0;
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off when the pressure phase begins.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (phase == PH_PRESSURE && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct(phase));
      end
    end
  end

  // Keeps the rough view of the stack in step with each accepted command.
  function automatic void track_command(logic [1:0] cmd);
    case (cmd)
      CMD_RECORD: begin
        if (seg_sizes.size() > 0 && shadow_fill < STACK_DEPTH) begin
          seg_sizes[seg_sizes.size() - 1]++;
          shadow_fill++;
        end
      end
      CMD_MARK: begin
        if (shadow_fill < STACK_DEPTH) begin
          seg_sizes.push_back(0);
          shadow_fill++;
        end
      end
      CMD_POP: begin
        if (seg_sizes.size() > 0) begin
          shadow_fill -= seg_sizes[seg_sizes.size() - 1] + 1;
          void'(seg_sizes.pop_back());
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Object handles lean towards the extremes now and then.
  function automatic logic [31:0] pick_object();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one word, with random idle cycles first, and returns once it is accepted.
  task automatic send_word(logic [1:0] cmd, logic [7:0] kind, logic [31:0] handle);
    in_word_t w;
    w.cmd       = cmd;
    w.op_type   = kind;
    w.op_object = handle;
    while ($urandom_range(0, 99) < send_idle_pct(phase)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_command(cmd);
  endtask

  task automatic send_random_record();
    send_word(CMD_RECORD, 8'($urandom_range(0, 255)), pick_object());
  endtask

  // Mostly well-formed milestone sequences; stray records and pops act as noise.
  task automatic send_random(int count);
    int         n;
    int         r;
    logic [1:0] cmd;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (seg_sizes.size() == 0) begin
        cmd = (r < 70) ? CMD_MARK : (r < 85) ? CMD_RECORD : (r < 95) ? CMD_POP : CMD_NONE;
      end else begin
        cmd = (r < 55) ? CMD_RECORD : (r < 70) ? CMD_MARK : (r < 93) ? CMD_POP : CMD_NONE;
      end
      send_word(cmd, 8'($urandom_range(0, 255)), pick_object());
    end
  endtask

  // Empties the stack, fills it to the brim behind one milestone, overflows it, then unwinds.
  task automatic fill_and_unwind();
    while (seg_sizes.size() > 0) send_word(CMD_POP, '0, '0);
    send_word(CMD_MARK, '0, '0);
    while (shadow_fill < STACK_DEPTH) send_random_record();
    send_random_record();
    send_word(CMD_MARK, 8'hff, '1);
    send_random_record();
    send_word(CMD_POP, '0, '0);
    send_word(CMD_POP, '0, '0);
  endtask

  // Main stimulus and verdict.
  initial begin
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: ignored record, pop without milestone, unused code, nesting, extremes.
    send_word(CMD_RECORD, 8'hff, 32'hffff_ffff);
    send_word(CMD_POP, 8'h00, 32'h0000_0000);
    send_word(CMD_NONE, 8'h5a, 32'h1234_5678);
    send_word(CMD_MARK, 8'h00, 32'h0000_0000);
    send_word(CMD_RECORD, 8'h00, 32'h0000_0000);
    send_word(CMD_RECORD, 8'hff, 32'hffff_ffff);
    send_word(CMD_RECORD, 8'haa, 32'h5555_5555);
    send_word(CMD_MARK, 8'h00, 32'h0000_0000);
    send_word(CMD_POP, 8'h00, 32'h0000_0000);
    send_word(CMD_RECORD, 8'h55, 32'haaaa_aaaa);
    send_word(CMD_RECORD, 8'h01, 32'h0000_0001);
    send_word(CMD_NONE, 8'hff, 32'hffff_ffff);
    send_word(CMD_POP, 8'h00, 32'h0000_0000);
    send_word(CMD_POP, 8'h00, 32'h0000_0000);
    send_word(CMD_MARK, 8'hff, 32'hffff_ffff);
    send_word(CMD_RECORD, 8'h80, 32'h8000_0000);
    send_word(CMD_POP, 8'hff, 32'hffff_ffff);

    // Random traffic under each idling pattern in turn.
    phase = PH_FREE;
    send_random(PHASE_WORDS);
    phase = PH_SEND_IDLE;
    send_random(PHASE_WORDS);
    phase = PH_RECV_STALL;
    send_random(PHASE_WORDS);
    phase = PH_BOTH;
    send_random(PHASE_WORDS);

    // The receiver holds off while the stack is filled, so the input side backs up.
    phase = PH_PRESSURE;
    fill_and_unwind();

    in_valid <= 1'b0;
    phase = PH_FREE;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/usm_pkg.sv
src/usm_front.sv
src/usm_cmd_fifo.sv
src/usm_back.sv
src/undo_stack_with_milestones_core.sv
dv/undo_checker.sv
dv/tb_top.sv
